/* rtl/sigp_pkg.sv */
`default_nettype none
package sigp_pkg;

  localparam int ADC_BITS = 12;
  localparam int SW = 2 * ADC_BITS + 1;
  localparam int EW = $clog2(SW);
  localparam int CW = ADC_BITS + 19;
  localparam int ZW = 25;
  localparam int PW = ZW + 2;
  localparam int DW = EW + 18;
  localparam int MW = DW + 21;
  localparam int TW = 50;
  localparam int STEPS = 16;
  localparam int QB = 13;

  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};
  localparam logic [EW-1:0] FS_EXP = EW'(ADC_BITS - 1);
  localparam logic [30:0] FS_MANT = 31'(FS) << (30 - (ADC_BITS - 1));

  localparam logic signed [TW-1:0] GAIN_BASE_Q32 = TW'(64'sd9884622 * 64'sd65536);
  localparam logic signed [20:0] LOG_SCALE_Q16 = 21'sd591849;
  localparam logic signed [PW-1:0] PHASE_BASE_Q16 = PW'(200 * 65536);
  localparam logic [29:0] AMP_DIVIDEND = 30'd864000000;
  localparam logic [11:0] AMP_FLAT_WORD = 12'd4075;
  localparam logic [11:0] AMP_MAX = 12'd4095;

  localparam logic [1:0] AMP_FLAT = 2'd0;
  localparam logic [1:0] AMP_LOW = 2'd1;
  localparam logic [1:0] AMP_HIGH = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_STOP = 2'd1;
  localparam logic [1:0] REG_LEFT = 2'd2;
  localparam logic [1:0] REG_RIGHT = 2'd3;

  localparam logic signed [ZW-1:0] ATAN_TAB [STEPS] = '{
    25'sd2950616, 25'sd1741850, 25'sd920346, 25'sd467182, 25'sd234498, 25'sd117363,
    25'sd58696, 25'sd29350, 25'sd14675, 25'sd7338, 25'sd3669, 25'sd1834, 25'sd917,
    25'sd459, 25'sd229, 25'sd115
  };

  typedef struct packed {
    logic [11:0] adc_i;
    logic [11:0] adc_q;
  } in_t;

  typedef struct packed {
    logic [9:0] dds_freq_tenths;
    logic [11:0] dds_amp_word;
    logic [7:0] plot_column;
    logic [8:0] gain_row;
    logic [7:0] phase_row;
    logic trace_wrapped;
    logic zero_vector;
  } out_t;

  typedef struct packed {
    logic [9:0] sweep_start_tenths;
    logic [9:0] sweep_stop_tenths;
    logic [7:0] plot_left_column;
    logic [7:0] plot_right_column;
  } cfg_t;

  typedef struct packed {
    logic [9:0] freq;
    logic [1:0] amp_mode;
    logic [18:0] denom;
    logic [7:0] column;
    logic wrapped;
    logic zero;
    logic [ADC_BITS-1:0] ai;
    logic [ADC_BITS-1:0] aq;
  } job_t;

endpackage
`default_nettype wire

/* rtl/sigp_front.sv */
`default_nettype none
module sigp_front (
  input wire logic clk,
  input wire logic rst,
  input wire sigp_pkg::cfg_t cfg,
  input wire logic in_valid,
  input wire sigp_pkg::in_t in_data,
  input wire logic full,
  output logic push,
  output sigp_pkg::job_t job
);

  logic [9:0] freq;
  logic [9:0] freq_next;
  logic [8:0] half_count;
  logic [8:0] half_count_next;
  logic [10:0] freq_inc;
  logic [7:0] col;

  always_comb begin
    push = in_valid && !full;
    freq_inc = {1'b0, freq} + 11'd1;
    freq_next = (freq_inc > {1'b0, cfg.sweep_stop_tenths}) ? cfg.sweep_start_tenths
                                                              : freq_inc[9:0];
    col = half_count[8:1];
    job.wrapped = (col >= cfg.plot_right_column);
    half_count_next = job.wrapped ? {cfg.plot_left_column, 1'b0} : half_count + 9'd1;
    job.freq = freq;
    job.column = col;
    job.ai = in_data.adc_i[sigp_pkg::ADC_BITS-1:0];
    job.aq = in_data.adc_q[sigp_pkg::ADC_BITS-1:0];
    job.zero = (job.ai == '0) && (job.aq == '0);
    if (freq < 10'd250) begin
      job.amp_mode = sigp_pkg::AMP_LOW;
      job.denom = 19'd267000 - 19'(freq) * 19'd235;
    end else if (freq > 10'd290) begin
      job.amp_mode = sigp_pkg::AMP_HIGH;
      job.denom = 19'd146000 + 19'(freq) * 19'd233;
    end else begin
      job.amp_mode = sigp_pkg::AMP_FLAT;
      job.denom = 19'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= 10'd11;
      half_count <= 9'd50;
    end else if (push) begin
      freq <= freq_next;
      half_count <= half_count_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/sigp_queue.sv */
`default_nettype none
module sigp_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic pop,
  input wire sigp_pkg::job_t wr_job,
  output sigp_pkg::job_t rd_job,
  output logic full,
  output logic empty
);

  sigp_pkg::job_t slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rd_job = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/sigp_back.sv */
`default_nettype none
module sigp_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic empty,
  input wire sigp_pkg::job_t job_in,
  output logic pop,
  output logic out_valid,
  input wire logic out_stall,
  output sigp_pkg::out_t out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_RUN = 3'd3;
  localparam logic [2:0] ST_MUL = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] st;
  sigp_pkg::job_t job;
  logic [3:0] k;
  logic [sigp_pkg::SW-1:0] s;
  logic [30:0] ms;
  logic [30:0] mf;
  logic [sigp_pkg::EW-1:0] es;
  logic [15:0] frs;
  logic [15:0] frf;
  logic signed [sigp_pkg::CW-1:0] x;
  logic signed [sigp_pkg::CW-1:0] y;
  logic signed [sigp_pkg::ZW-1:0] z;
  logic [29:0] rem;
  logic [sigp_pkg::QB-1:0] quo;
  logic signed [sigp_pkg::MW-1:0] prod;

  logic [sigp_pkg::EW-1:0] e_lead;
  logic [sigp_pkg::SW+29:0] norm;
  logic [61:0] sq_s;
  logic [61:0] sq_f;
  logic [31:0] ts;
  logic [31:0] tf;
  logic signed [sigp_pkg::CW-1:0] dx;
  logic signed [sigp_pkg::CW-1:0] dy;
  logic signed [sigp_pkg::CW-1:0] yneg;
  logic [30:0] trial;
  logic signed [sigp_pkg::DW-1:0] d;
  logic signed [sigp_pkg::TW-1:0] t;
  logic signed [sigp_pkg::ZW-1:0] zf;
  logic signed [sigp_pkg::PW-1:0] p;
  logic [8:0] grow;
  logic [7:0] prow;
  logic [11:0] amp;
  logic load;

  always_comb begin
    e_lead = '0;
    for (int b = 0; b < sigp_pkg::SW; b++) begin
      if (s[b]) begin
        e_lead = sigp_pkg::EW'(b);
      end
    end
    norm = {s, 30'b0} >> e_lead;
    sq_s = 62'(ms) * 62'(ms);
    sq_f = 62'(mf) * 62'(mf);
    ts = sq_s[61:30];
    tf = sq_f[61:30];
    yneg = -y;
    dx = (y >= 0) ? (y >>> k) : -(yneg >>> k);
    dy = x >>> k;
    trial = 31'(job.denom) << (4'd12 - k);
    d = (sigp_pkg::DW'({sigp_pkg::FS_EXP, frf}) <<< 1) - sigp_pkg::DW'({es, frs});
    t = sigp_pkg::GAIN_BASE_Q32 + sigp_pkg::TW'(prod);
    if (job.aq == '0) begin
      zf = '0;
    end else if (job.ai == '0) begin
      zf = sigp_pkg::ATAN_TAB[0] <<< 1;
    end else begin
      zf = z;
    end
    p = sigp_pkg::PHASE_BASE_Q16 - (sigp_pkg::PW'(zf) <<< 1);
    if (job.zero) begin
      grow = 9'd511;
      prow = 8'd200;
    end else begin
      if (t < 0) begin
        grow = 9'd0;
      end else if (t[sigp_pkg::TW-1:32] > 18'd511) begin
        grow = 9'd511;
      end else begin
        grow = t[40:32];
      end
      if (p < 0) begin
        prow = 8'd0;
      end else if (p[sigp_pkg::PW-1:16] > 11'd255) begin
        prow = 8'd255;
      end else begin
        prow = p[23:16];
      end
    end
    unique case (job.amp_mode)
      sigp_pkg::AMP_LOW, sigp_pkg::AMP_HIGH: begin
        amp = (quo > 13'(sigp_pkg::AMP_MAX)) ? sigp_pkg::AMP_MAX : quo[11:0];
      end
      default: begin
        amp = sigp_pkg::AMP_FLAT_WORD;
      end
    endcase
    pop = (st == ST_IDLE) && !empty;
    load = (st == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: if (pop) st <= ST_SQ;
        ST_SQ: st <= ST_NORM;
        ST_NORM: st <= ST_RUN;
        ST_RUN: if (k == 4'd15) st <= ST_MUL;
        ST_MUL: st <= ST_DONE;
        ST_DONE: if (load) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      ST_IDLE: begin
        job <= job_in;
      end
      ST_SQ: begin
        s <= sigp_pkg::SW'(job.ai) * sigp_pkg::SW'(job.ai)
           + sigp_pkg::SW'(job.aq) * sigp_pkg::SW'(job.aq);
        mf <= sigp_pkg::FS_MANT;
        x <= sigp_pkg::CW'(job.ai) <<< 16;
        y <= sigp_pkg::CW'(job.aq) <<< 16;
        z <= '0;
        rem <= sigp_pkg::AMP_DIVIDEND;
        quo <= '0;
        k <= 4'd0;
      end
      ST_NORM: begin
        es <= e_lead;
        ms <= norm[30:0];
      end
      ST_RUN: begin
        if (ts[31]) begin
          ms <= ts[31:1];
        end else begin
          ms <= ts[30:0];
        end
        if (tf[31]) begin
          mf <= tf[31:1];
        end else begin
          mf <= tf[30:0];
        end
        frs <= {frs[14:0], ts[31]};
        frf <= {frf[14:0], tf[31]};
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + sigp_pkg::ATAN_TAB[k];
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - sigp_pkg::ATAN_TAB[k];
        end
        if (k <= 4'd12) begin
          if ({1'b0, rem} >= trial) begin
            rem <= rem - trial[29:0];
            quo <= {quo[sigp_pkg::QB-2:0], 1'b1};
          end else begin
            quo <= {quo[sigp_pkg::QB-2:0], 1'b0};
          end
        end
        k <= k + 4'd1;
      end
      ST_MUL: begin
        prod <= sigp_pkg::MW'(d) * sigp_pkg::MW'(sigp_pkg::LOG_SCALE_Q16);
      end
      default: begin
      end
    endcase
    if (load) begin
      out_data.dds_freq_tenths <= job.freq;
      out_data.dds_amp_word <= amp;
      out_data.plot_column <= job.column;
      out_data.gain_row <= grow;
      out_data.phase_row <= prow;
      out_data.trace_wrapped <= job.wrapped;
      out_data.zero_vector <= job.zero;
    end
  end

endmodule
`default_nettype wire

/* rtl/sweep_iq_gain_phase_plotter_top.sv */
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_data (adc_i, adc_q)
// out      output     out_valid / out_stall out_data (freq, amp, column, rows, flags)
// cfg      input      cfg_en               cfg_index, cfg_data
// In the back end a point passes through these steps in order: pop the queue, square, normalize,
// 16 iterations of log2 squaring and CORDIC (the first 13 also divide for amplitude), multiply, finish.
// The front end accepts a point whenever the two-entry queue has room.
// rst is synchronous; it restores config, sweep and control state and empties the queue (not data regs).
// A stalled result holds in the output register while the back end finishes the next.
`default_nettype none
module sweep_iq_gain_phase_plotter_top (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire sigp_pkg::in_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output sigp_pkg::out_t out_data,
  input wire logic cfg_en,
  input wire logic [1:0] cfg_index,
  input wire logic [9:0] cfg_data
);

  sigp_pkg::cfg_t cfg;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  sigp_pkg::job_t wr_job;
  sigp_pkg::job_t rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_start_tenths <= 10'd10;
      cfg.sweep_stop_tenths <= 10'd400;
      cfg.plot_left_column <= 8'd25;
      cfg.plot_right_column <= 8'd211;
    end else if (cfg_en) begin
      unique case (cfg_index)
        sigp_pkg::REG_START: cfg.sweep_start_tenths <= cfg_data;
        sigp_pkg::REG_STOP: cfg.sweep_stop_tenths <= cfg_data;
        sigp_pkg::REG_LEFT: cfg.plot_left_column <= cfg_data[7:0];
        sigp_pkg::REG_RIGHT: cfg.plot_right_column <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;

  sigp_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_data(in_data),
    .full(q_full),
    .push(q_push),
    .job(wr_job)
  );

  sigp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .pop(q_pop),
    .wr_job(wr_job),
    .rd_job(rd_job),
    .full(q_full),
    .empty(q_empty)
  );

  sigp_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(q_empty),
    .job_in(rd_job),
    .pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_sweep_iq_gain_phase_plotter_top.sv */
`default_nettype none
module tb_sweep_iq_gain_phase_plotter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 48;
  localparam longint ATAN_Q16 [16] = '{
    2950616, 1741850, 920346, 467182, 234498, 117363, 58696, 29350,
    14675, 7338, 3669, 1834, 917, 459, 229, 115
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sigp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sigp_pkg::out_t out_data;
  logic cfg_en = 1'b0;
  logic [1:0] cfg_index = sigp_pkg::REG_START;
  logic [9:0] cfg_data = '0;

  sweep_iq_gain_phase_plotter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  sigp_pkg::cfg_t sweep_cfg;
  logic [9:0] freq_now;
  logic [8:0] half_col;
  sigp_pkg::out_t expected_points[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit hold_out = 1'b0;

  function automatic longint log2_fix(longint unsigned v);
    longint unsigned m;
    int e;
    longint frac;
    e = 0;
    frac = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    if (e >= 30) m = v >> (e - 30);
    else m = v << (30 - e);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << b);
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic longint half_toward_zero(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v) >>> k);
  endfunction

  function automatic longint phase_fix(longint i, longint q);
    longint x, y, z, dx, dy;
    x = i << 16;
    y = q << 16;
    z = 0;
    if (q == 0) return 0;
    if (i == 0) return 2 * ATAN_Q16[0];
    for (int k = 0; k < 16; k++) begin
      dx = half_toward_zero(y, k);
      dy = x >>> k;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q16[k];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[k];
      end
    end
    return z;
  endfunction

  function automatic sigp_pkg::out_t sweep_point(sigp_pkg::in_t d);
    sigp_pkg::out_t r;
    longint f, amp, nf, col, s, dd, t, p, g, pr;
    f = freq_now;
    if (f < 250) amp = 864000000 / (267000 - 235 * f);
    else if (f > 290) amp = 864000000 / (146000 + 233 * f);
    else amp = 4075;
    if (amp > 4095) amp = 4095;
    nf = f + 1;
    if (nf > sweep_cfg.sweep_stop_tenths) nf = sweep_cfg.sweep_start_tenths;
    freq_now = nf[9:0];
    col = half_col >> 1;
    half_col = half_col + 9'd1;
    r = '0;
    if (col >= sweep_cfg.plot_right_column) begin
      half_col = {sweep_cfg.plot_left_column, 1'b0};
      r.trace_wrapped = 1'b1;
    end
    if (d.adc_i == 0 && d.adc_q == 0) begin
      r.zero_vector = 1'b1;
      g = 511;
      pr = 200;
    end else begin
      s = longint'(d.adc_i) * d.adc_i + longint'(d.adc_q) * d.adc_q;
      dd = 2 * log2_fix(4095) - log2_fix(s);
      t = 64'sd9884622 * 65536 + 64'sd591849 * dd;
      p = 200 * 65536 - 2 * phase_fix(d.adc_i, d.adc_q);
      g = (t < 0) ? 0 : (t >>> 32);
      if (g > 511) g = 511;
      pr = (p < 0) ? 0 : (p >>> 16);
      if (pr > 255) pr = 255;
    end
    r.dds_freq_tenths = f[9:0];
    r.dds_amp_word = amp[11:0];
    r.plot_column = col[7:0];
    r.gain_row = g[8:0];
    r.phase_row = pr[7:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_out) out_stall <= 1'b1;
    else if (idle_on) out_stall <= ($urandom_range(99) < 26);
    else out_stall <= 1'b0;
  end

  always @(negedge clk) begin
    sigp_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report("unexpected transaction", out_data, 0);
      end else begin
        want = expected_points.pop_front();
        if (out_data.dds_freq_tenths != want.dds_freq_tenths)
          report("dds_freq_tenths", out_data.dds_freq_tenths, want.dds_freq_tenths);
        if (out_data.dds_amp_word != want.dds_amp_word)
          report("dds_amp_word", out_data.dds_amp_word, want.dds_amp_word);
        if (out_data.plot_column != want.plot_column)
          report("plot_column", out_data.plot_column, want.plot_column);
        if (out_data.gain_row != want.gain_row)
          report("gain_row", out_data.gain_row, want.gain_row);
        if (out_data.phase_row != want.phase_row)
          report("phase_row", out_data.phase_row, want.phase_row);
        if (out_data.trace_wrapped != want.trace_wrapped)
          report("trace_wrapped", out_data.trace_wrapped, want.trace_wrapped);
        if (out_data.zero_vector != want.zero_vector)
          report("zero_vector", out_data.zero_vector, want.zero_vector);
      end
    end
  end

  task automatic send_point(logic [11:0] ai, logic [11:0] aq);
    sigp_pkg::in_t d;
    bit stalled;
    d.adc_i = ai;
    d.adc_q = aq;
    while (idle_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    expected_points.push_back(sweep_point(d));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      sigp_pkg::REG_START: sweep_cfg.sweep_start_tenths = val;
      sigp_pkg::REG_STOP: sweep_cfg.sweep_stop_tenths = val;
      sigp_pkg::REG_LEFT: sweep_cfg.plot_left_column = val[7:0];
      default: sweep_cfg.plot_right_column = val[7:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_sweep(int start, int stop, int left, int right);
    wait_idle();
    write_reg(sigp_pkg::REG_START, start[9:0]);
    write_reg(sigp_pkg::REG_STOP, stop[9:0]);
    write_reg(sigp_pkg::REG_LEFT, left[9:0]);
    write_reg(sigp_pkg::REG_RIGHT, right[9:0]);
  endtask

  function automatic logic [11:0] rand_sample();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'(1 << $urandom_range(11));
      3: return 12'($urandom_range(15));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_point(12'd0, 12'd0);
    send_point(12'hFFF, 12'hFFF);
    send_point(12'hFFF, 12'd0);
    send_point(12'd0, 12'hFFF);
    send_point(12'd1, 12'd0);
    send_point(12'd0, 12'd1);
    send_point(12'd1, 12'd1);
    send_point(12'hAAA, 12'h555);
    send_point(12'h555, 12'hAAA);
    send_point(12'd1, 12'hFFF);
    send_point(12'hFFF, 12'd1);
    send_point(12'd2048, 12'd2048);
  endtask

  task automatic test_sweep_extremes();
    set_sweep(1, 1000, 0, 255);
    repeat (20) send_point(rand_sample(), rand_sample());
    set_sweep(245, 296, 255, 0);
    repeat (60) send_point(rand_sample(), rand_sample());
    set_sweep(700, 300, 100, 120);
    repeat (12) send_point(rand_sample(), rand_sample());
    set_sweep(990, 1000, 200, 10);
    repeat (15) send_point(rand_sample(), rand_sample());
  endtask

  task automatic test_random_points();
    set_sweep(1, 1000, 3, 60);
    repeat (250) send_point(rand_sample(), rand_sample());
    set_sweep($urandom_range(1, 1000), $urandom_range(1, 1000),
              $urandom_range(255), $urandom_range(255));
    idle_on = 1'b0;
    repeat (100) send_point(rand_sample(), rand_sample());
    idle_on = 1'b1;
    repeat (150) send_point(rand_sample(), rand_sample());
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      repeat (80) send_point(rand_sample(), rand_sample());
    join
  endtask

  initial begin
    sweep_cfg.sweep_start_tenths = 10'd10;
    sweep_cfg.sweep_stop_tenths = 10'd400;
    sweep_cfg.plot_left_column = 8'd25;
    sweep_cfg.plot_right_column = 8'd211;
    freq_now = 10'd11;
    half_col = 9'd50;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sweep_extremes();
    test_random_points();
    test_back_pressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
